// ===== rtl/core/websocket_frame_deframer_macros.svh =====
// ---------------------------------------------------------------------------
// websocket_frame_deframer_macros
// Assertion macros shared by the deframer modules.
// ---------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`ifndef SYNTHESIS
`define WSFD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("wsfd assertion failed");
`define WSFD_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("wsfd assertion failed");
`else
`define WSFD_ASSERT(label, clk, rst, prop)
`define WSFD_ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

// ===== rtl/core/wsfd_pkg.sv =====
// ---------------------------------------------------------------------------
// wsfd_pkg
// Types and constants of the websocket frame deframer.
// ---------------------------------------------------------------------------
package wsfd_pkg;

   typedef enum logic [2:0] {
      KIND_DATA  = 3'd0,
      KIND_EMPTY = 3'd1,
      KIND_CLOSE = 3'd2,
      KIND_RSV   = 3'd3,
      KIND_TRUNC = 3'd4,
      KIND_LONG  = 3'd5
   } kind_type;

   localparam logic [3:0] OPC_CLOSE   = 4'h8;
   localparam logic [6:0] LEN_EXT16   = 7'd126;
   localparam logic [6:0] LEN_EXT64   = 7'd127;
   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;
   localparam logic [3:0] MASK_BYTES  = 4'd4;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       buffer_end;
   } item_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic [3:0] opcode;
      logic       frame_last;
   } rslt_type;

endpackage

// ===== rtl/core/wsfd_parser.sv =====
// ---------------------------------------------------------------------------
// wsfd_parser
// Frame header parser and payload unmasker, one byte per step.
// ---------------------------------------------------------------------------
`include "websocket_frame_deframer_macros.svh"

module wsfd_parser
   import wsfd_pkg::*;
#(
   parameter int MAX_PAYLOAD = 4096
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     step,
   input  item_type item,
   output logic     res_valid,
   output rslt_type res
);

   localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);

   typedef enum logic [2:0] {
      PH_FIRST   = 3'd0,
      PH_SECOND  = 3'd1,
      PH_EXTLEN  = 3'd2,
      PH_MASK    = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_DROP    = 3'd5
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  left_ff, left_in;
   logic [15:0] len_ff, len_in;
   logic        ovf_ff, ovf_in;
   logic [31:0] key_ff, key_in;
   logic        masked_ff, masked_in;
   logic [15:0] idx_ff, idx_in;
   logic [3:0]  opc_ff, opc_in;

   logic       do_after;
   logic       do_hdr;
   logic [7:0] b;
   logic       e;
   logic [7:0] kb;

   always_comb begin
      b         = item.rx_byte;
      e         = item.buffer_end;
      phase_in  = phase_ff;
      left_in   = left_ff;
      len_in    = len_ff;
      ovf_in    = ovf_ff;
      key_in    = key_ff;
      masked_in = masked_ff;
      idx_in    = idx_ff;
      opc_in    = opc_ff;
      do_after  = 1'b0;
      do_hdr    = 1'b0;
      res_valid = 1'b0;
      res.kind  = KIND_DATA;
      res.data  = 8'h00;
      res.frame_last = 1'b0;
      // key byte for this payload position, first key byte at index 0 mod 4
      kb = 8'(key_ff >> {~idx_ff[1:0], 3'b000});

      unique case (phase_ff)
         PH_FIRST: begin
            opc_in    = b[3:0];
            len_in    = 16'h0000;
            ovf_in    = 1'b0;
            key_in    = 32'h0;
            masked_in = 1'b0;
            idx_in    = 16'h0000;
            left_in   = 4'h0;
            if (e) begin
               phase_in = PH_FIRST;
               res_valid = 1'b1;
               res.kind = KIND_TRUNC;
               res.frame_last = 1'b1;
            end else if (b[3:0] == OPC_CLOSE) begin
               phase_in = PH_DROP;
               res_valid = 1'b1;
               res.kind = KIND_CLOSE;
               res.frame_last = 1'b1;
            end else if (b[6:4] != 3'b000) begin
               phase_in = PH_DROP;
               res_valid = 1'b1;
               res.kind = KIND_RSV;
               res.frame_last = 1'b1;
            end else begin
               phase_in = PH_SECOND;
            end
         end
         PH_SECOND: begin
            masked_in = b[7];
            if (b[6:0] == LEN_EXT16 || b[6:0] == LEN_EXT64) begin
               left_in  = (b[6:0] == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
               phase_in = PH_EXTLEN;
               if (e) begin
                  phase_in = PH_FIRST;
                  res_valid = 1'b1;
                  res.kind = KIND_TRUNC;
                  res.frame_last = 1'b1;
               end
            end else begin
               len_in   = {9'b0, b[6:0]};
               do_after = 1'b1;
            end
         end
         PH_EXTLEN: begin
            // bits shifted out of the 16-bit window mean the length is too big
            if (len_ff[15:8] != 8'h00) begin
               ovf_in = 1'b1;
            end
            len_in  = {len_ff[7:0], b};
            left_in = left_ff - 4'd1;
            if (left_in == 4'h0) begin
               do_after = 1'b1;
            end else if (e) begin
               phase_in = PH_FIRST;
               res_valid = 1'b1;
               res.kind = KIND_TRUNC;
               res.frame_last = 1'b1;
            end
         end
         PH_MASK: begin
            key_in  = {key_ff[23:0], b};
            left_in = left_ff - 4'd1;
            if (left_in == 4'h0) begin
               do_hdr = 1'b1;
            end else if (e) begin
               phase_in = PH_FIRST;
               res_valid = 1'b1;
               res.kind = KIND_TRUNC;
               res.frame_last = 1'b1;
            end
         end
         PH_PAYLOAD: begin
            idx_in = idx_ff + 16'd1;
            res_valid = 1'b1;
            if (idx_in >= len_ff) begin
               phase_in = e ? PH_FIRST : PH_DROP;
               res.kind = KIND_DATA;
               res.data = b ^ kb;
               res.frame_last = 1'b1;
            end else if (e) begin
               phase_in = PH_FIRST;
               res.kind = KIND_TRUNC;
               res.frame_last = 1'b1;
            end else begin
               res.kind = KIND_DATA;
               res.data = b ^ kb;
            end
         end
         PH_DROP: begin
            if (e) begin
               phase_in = PH_FIRST;
            end
         end
         default: begin
            phase_in = PH_FIRST;
         end
      endcase

      if (do_after) begin
         if (masked_in) begin
            left_in  = MASK_BYTES;
            phase_in = PH_MASK;
            if (e) begin
               phase_in = PH_FIRST;
               res_valid = 1'b1;
               res.kind = KIND_TRUNC;
               res.frame_last = 1'b1;
            end
         end else begin
            do_hdr = 1'b1;
         end
      end

      if (do_hdr) begin
         if (len_in > MAX_LEN) begin
            ovf_in = 1'b1;
         end
         idx_in = 16'h0000;
         if (ovf_in) begin
            phase_in = e ? PH_FIRST : PH_DROP;
            res_valid = 1'b1;
            res.kind = KIND_LONG;
            res.frame_last = 1'b1;
         end else if (len_in == 16'h0000) begin
            phase_in = e ? PH_FIRST : PH_DROP;
            res_valid = 1'b1;
            res.kind = KIND_EMPTY;
            res.frame_last = 1'b1;
         end else if (e) begin
            phase_in = PH_FIRST;
            res_valid = 1'b1;
            res.kind = KIND_TRUNC;
            res.frame_last = 1'b1;
         end else begin
            phase_in = PH_PAYLOAD;
         end
      end

      res.opcode = opc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_FIRST;
         left_ff   <= 4'h0;
         len_ff    <= 16'h0000;
         ovf_ff    <= 1'b0;
         key_ff    <= 32'h0;
         masked_ff <= 1'b0;
         idx_ff    <= 16'h0000;
         opc_ff    <= 4'h0;
      end else if (step) begin
         phase_ff  <= phase_in;
         left_ff   <= left_in;
         len_ff    <= len_in;
         ovf_ff    <= ovf_in;
         key_ff    <= key_in;
         masked_ff <= masked_in;
         idx_ff    <= idx_in;
         opc_ff    <= opc_in;
      end
   end

   `WSFD_ASSERT(a_idx_in_range, clock, reset, phase_ff == PH_PAYLOAD |-> idx_ff < len_ff)
   `WSFD_ASSERT(a_len_limit, clock, reset, phase_ff == PH_PAYLOAD |-> len_ff <= MAX_LEN && !ovf_ff)
   `WSFD_ASSERT(a_hdr_count, clock, reset, phase_ff == PH_EXTLEN || phase_ff == PH_MASK |-> left_ff != 4'h0)

endmodule

// ===== rtl/core/wsfd_out_buf.sv =====
// ---------------------------------------------------------------------------
// wsfd_out_buf
// Result register between the parser and the result channel.
// ---------------------------------------------------------------------------
module wsfd_out_buf
   import wsfd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     load,
   input  rslt_type load_rslt,
   output logic     free,
   input  logic     rsp_ready,
   output logic     rsp_valid,
   output rslt_type rsp_rslt
);

   logic     valid_ff, valid_in;
   rslt_type rslt_ff;

   assign free     = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rslt_ff <= load_rslt;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_rslt  = rslt_ff;

endmodule

// ===== rtl/core/websocket_frame_deframer.sv =====
// ---------------------------------------------------------------------------
// websocket_frame_deframer
// Receive-side websocket frame parser: header, extended length, mask key,
// unmasked payload bytes and frame status results.
// ---------------------------------------------------------------------------
//  channel  direction  ports
//  req      in         req_valid req_ready req_rx_byte req_buffer_end
//  rsp      out        rsp_valid rsp_ready rsp_kind rsp_data rsp_opcode rsp_frame_last
//
//  one item per cycle while the result register is free or rsp_ready is high; a
//  result passes from the input register through the parser into the result register
//  items that cause no result pass through the input register and vanish
//  synchronous reset returns the parser to the first header byte
//  rsp_ready low holds the result; req_ready drops once the input register
//  also holds an item
// ---------------------------------------------------------------------------
`include "websocket_frame_deframer_macros.svh"

module websocket_frame_deframer
   import wsfd_pkg::*;
#(
   parameter int MAX_PAYLOAD = 4096
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   input  logic       req_buffer_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_kind,
   output logic [7:0] rsp_data,
   output logic [3:0] rsp_opcode,
   output logic       rsp_frame_last
);

   logic     in_valid_ff, in_valid_in;
   item_type in_item_ff;
   logic     out_free;
   logic     advance;
   logic     req_fire;
   logic     res_valid;
   rslt_type res;
   rslt_type out_rslt;

   assign advance     = in_valid_ff && out_free;
   assign req_ready   = !in_valid_ff || out_free;
   assign req_fire    = req_valid && req_ready;
   assign in_valid_in = req_fire || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff.rx_byte    <= req_rx_byte;
         in_item_ff.buffer_end <= req_buffer_end;
      end
   end

   wsfd_parser #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_parser (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .item     (in_item_ff),
      .res_valid(res_valid),
      .res      (res)
   );

   wsfd_out_buf u_out_buf (
      .clock    (clock),
      .reset    (reset),
      .load     (advance && res_valid),
      .load_rslt(res),
      .free     (out_free),
      .rsp_ready(rsp_ready),
      .rsp_valid(rsp_valid),
      .rsp_rslt (out_rslt)
   );

   assign rsp_kind       = out_rslt.kind;
   assign rsp_data       = out_rslt.data;
   assign rsp_opcode     = out_rslt.opcode;
   assign rsp_frame_last = out_rslt.frame_last;

   `WSFD_ASSERT(a_data_zero, clock, reset, rsp_valid && rsp_kind != KIND_DATA |-> rsp_data == 8'h00)
   `WSFD_ASSERT(a_mid_is_data, clock, reset, rsp_valid && !rsp_frame_last |-> rsp_kind == KIND_DATA)
   `WSFD_ASSERT(a_stall_only, clock, reset, !req_ready |-> rsp_valid && !rsp_ready)

endmodule
